// ===== design/sensor_sample_ring_buffer_defines.svh =====
// Assertion helpers shared by the ring buffer top level.
`ifndef SENSOR_SAMPLE_RING_BUFFER_DEFINES_SVH
`define SENSOR_SAMPLE_RING_BUFFER_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define SSRB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define SSRB_NEVER(label, cond, msg) \
    `SSRB_ASSERT(label, !(cond), msg)

`endif

// ===== design/ssrb_pkg.sv =====
// ----------------------------------------------------------------------------
// ssrb_pkg
// Types and fixed constants of the sensor sample ring buffer.
// ----------------------------------------------------------------------------
package ssrb_pkg;

    localparam int REQ_N_W     = 7;   // width of a read length
    localparam int RES_CNT_W   = 9;   // width of the reported unread count
    localparam int QUEUE_DEPTH = 4;   // entries between front and back

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
    } t_sample;

    typedef struct packed {
        logic               func;
        logic [7:0]         tag_in;
        logic [15:0]        word_a_in;
        logic [15:0]        word_b_in;
        logic [15:0]        word_c_in;
        logic [REQ_N_W-1:0] read_count;
    } t_req;

    typedef struct packed {
        logic                 accepted;
        logic [7:0]           tag_out;
        logic [15:0]          word_a_out;
        logic [15:0]          word_b_out;
        logic [15:0]          word_c_out;
        logic                 last;
        logic [RES_CNT_W-1:0] unread_after;
    } t_res;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_READ = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_READ,
        OP_REJECT
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [REQ_N_W-1:0] n;
        t_sample            sample;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_BURST
    } t_back_state;

endpackage

// ===== design/sensor_sample_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// sensor_sample_ring_buffer
// Ring buffer of sensor samples that overwrites the oldest when full.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low.
// func 0 pushes one sample and gives no result; func 1 asks for read_count
// samples. A read that can be served gives read_count results, oldest first,
// the final one marked with last; any other read gives one rejected result.
// Each result is shown on o_res for one cycle with o_res_valid high and is
// taken at the edge that ends that cycle; the receiver cannot stall.
// The front end keeps the pointers and count and classifies each request in
// the cycle it is taken, then hands it through a four-entry queue to the
// back end, which owns the sample memory. A push is written to memory as it
// is popped. A served read is popped in the idle state and then read out in
// the burst state; its results pass the registered memory read and come out
// one per cycle. A rejected read is popped and answered from the result stage.
// busy is high only while the queue is full, i.e. while long reads back up.
// Synchronous reset empties the ring and the queue; memory contents are kept.
// ----------------------------------------------------------------------------
`include "sensor_sample_ring_buffer_defines.svh"

module sensor_sample_ring_buffer import ssrb_pkg::*; #(
    parameter int DEPTH     = 512,
    parameter int MAX_BURST = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_res_valid,
    output t_res o_res
);

    localparam int AW = $clog2(DEPTH);

    logic          w_push;
    t_cmd          w_enq_cmd;
    logic [AW-1:0] w_enq_addr;
    logic [AW-1:0] w_enq_cnt;
    logic [AW-1:0] w_unread;
    logic          w_full;
    logic          w_empty;
    logic          w_pop;
    t_cmd          w_deq_cmd;
    logic [AW-1:0] w_deq_addr;
    logic [AW-1:0] w_deq_cnt;
    logic          w_res_reject;
    logic          w_reject_clean;
    logic          w_res_sample;
    logic          w_burst_mid;

    ssrb_front #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .i_full   (w_full),
        .busy     (busy),
        .o_push   (w_push),
        .o_cmd    (w_enq_cmd),
        .o_addr   (w_enq_addr),
        .o_cnt    (w_enq_cnt),
        .o_unread (w_unread)
    );

    ssrb_queue #(
        .AW (AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_enq_cmd),
        .i_addr  (w_enq_addr),
        .i_cnt   (w_enq_cnt),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cmd   (w_deq_cmd),
        .o_addr  (w_deq_addr),
        .o_cnt   (w_deq_cnt)
    );

    ssrb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_cmd       (w_deq_cmd),
        .i_addr      (w_deq_addr),
        .i_cnt       (w_deq_cnt),
        .o_pop       (w_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    assign w_res_reject   = o_res_valid && !o_res.accepted;
    assign w_reject_clean = o_res.last && (o_res.tag_out == '0)
                         && (o_res.word_a_out == '0) && (o_res.word_b_out == '0)
                         && (o_res.word_c_out == '0);
    assign w_res_sample   = o_res_valid && o_res.accepted;
    assign w_burst_mid    = w_res_sample && !o_res.last;

    // The ring never holds more than DEPTH-1 unread samples.
    `SSRB_NEVER(a_count_bound, w_unread > AW'(DEPTH - 1), "unread count exceeds capacity")
    // A rejected read is a single, final result with no sample data.
    `SSRB_ASSERT(a_reject_shape, w_res_reject |-> w_reject_clean, "malformed rejected result")
    // A served burst streams without gaps until its final sample.
    `SSRB_ASSERT(a_burst_gapless, w_burst_mid |=> w_res_sample, "gap inside a read burst")
    // Nothing is popped from an empty queue.
    `SSRB_NEVER(a_pop_empty, w_pop && w_empty, "back end popped an empty queue")

endmodule

// ===== design/ssrb_front.sv =====
// ----------------------------------------------------------------------------
// ssrb_front
// Takes requests, keeps the ring pointers and count, and classifies each
// request into a push, a served read or a rejected read for the back end.
// ----------------------------------------------------------------------------
module ssrb_front import ssrb_pkg::*; #(
    parameter int DEPTH     = 512,
    parameter int MAX_BURST = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  t_req                       i_req,
    input  logic                       i_full,
    output logic                       busy,
    output logic                       o_push,
    output t_cmd                       o_cmd,
    output logic [$clog2(DEPTH)-1:0]   o_addr,
    output logic [$clog2(DEPTH)-1:0]   o_cnt,
    output logic [$clog2(DEPTH)-1:0]   o_unread
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = AW + REQ_N_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

    logic [AW-1:0] r_wr_pos, n_wr_pos;
    logic [AW-1:0] r_rd_pos, n_rd_pos;
    logic [AW-1:0] r_count,  n_count;

    logic          accept;
    logic          ring_full;
    logic          read_bad;
    logic [SW-1:0] rd_sum;
    logic [SW-1:0] rd_wrap;

    assign busy     = i_full;
    assign accept   = start && !i_full;
    assign o_push   = accept;
    assign o_unread = r_count;

    assign ring_full = (r_count == LAST_SLOT);
    assign read_bad  = (i_req.read_count == '0)
                    || (i_req.read_count > REQ_N_W'(MAX_BURST))
                    || ({{AW{1'b0}}, i_req.read_count} > {{REQ_N_W{1'b0}}, r_count});
    // A served read never passes more than DEPTH-1 slots, so one subtract wraps it.
    assign rd_sum  = {{REQ_N_W{1'b0}}, r_rd_pos} + {{AW{1'b0}}, i_req.read_count};
    assign rd_wrap = (rd_sum >= DEPTH_S) ? (rd_sum - DEPTH_S) : rd_sum;

    always_comb begin
        n_wr_pos          = r_wr_pos;
        n_rd_pos          = r_rd_pos;
        n_count           = r_count;
        o_cmd.op          = OP_REJECT;
        o_cmd.n           = i_req.read_count;
        o_cmd.sample      = '{tag: i_req.tag_in, word_a: i_req.word_a_in,
                              word_b: i_req.word_b_in, word_c: i_req.word_c_in};
        o_addr            = r_rd_pos;
        o_cnt             = r_count;
        unique case (t_func'(i_req.func))
            FUNC_PUSH: begin
                o_cmd.op = OP_PUSH;
                o_addr   = r_wr_pos;
                n_wr_pos = (r_wr_pos == LAST_SLOT) ? '0 : r_wr_pos + 1'b1;
                if (ring_full) begin
                    // The oldest sample is dropped to make room.
                    n_rd_pos = (r_rd_pos == LAST_SLOT) ? '0 : r_rd_pos + 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            FUNC_READ: begin
                if (!read_bad) begin
                    o_cmd.op = OP_READ;
                    n_rd_pos = rd_wrap[AW-1:0];
                    n_count  = r_count - AW'(i_req.read_count);
                end
            end
            default: begin
                o_cmd.op = OP_REJECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_rd_pos <= '0;
            r_count  <= '0;
        end else if (accept) begin
            r_wr_pos <= n_wr_pos;
            r_rd_pos <= n_rd_pos;
            r_count  <= n_count;
        end
    end

endmodule

// ===== design/ssrb_queue.sv =====
// ----------------------------------------------------------------------------
// ssrb_queue
// Short command queue that lets the front end run ahead of the back end.
// ----------------------------------------------------------------------------
module ssrb_queue import ssrb_pkg::*; #(
    parameter int AW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cmd          i_cmd,
    input  logic [AW-1:0] i_addr,
    input  logic [AW-1:0] i_cnt,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_addr,
    output logic [AW-1:0] o_cnt
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_cmd_q  [QUEUE_DEPTH];
    logic [AW-1:0] r_addr_q [QUEUE_DEPTH];
    logic [AW-1:0] r_cnt_q  [QUEUE_DEPTH];
    logic [QW-1:0] r_wp, r_rp;
    logic [FW-1:0] r_fill;

    assign o_full  = (r_fill == FW'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_cmd   = r_cmd_q[r_rp];
    assign o_addr  = r_addr_q[r_rp];
    assign o_cnt   = r_cnt_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd_q[r_wp]  <= i_cmd;
            r_addr_q[r_wp] <= i_addr;
            r_cnt_q[r_wp]  <= i_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ===== design/ssrb_back.sv =====
// ----------------------------------------------------------------------------
// ssrb_back
// Carries out queued commands against the sample memory: writes pushes,
// streams served reads one sample per cycle and reports rejected reads.
// ----------------------------------------------------------------------------
module ssrb_back import ssrb_pkg::*; #(
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  t_cmd                     i_cmd,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [$clog2(DEPTH)-1:0] i_cnt,
    output logic                     o_pop,
    output logic                     o_res_valid,
    output t_res                     o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    t_back_state r_state, n_state;

    t_sample            r_mem [DEPTH];
    t_sample            r_mem_q;
    logic [AW-1:0]      r_addr;
    logic [REQ_N_W-1:0] r_left;
    logic [AW-1:0]      r_cnt;

    logic r_out_valid;
    logic r_out_acc;
    logic r_out_last;
    logic [AW-1:0] r_out_cnt;

    logic mem_we;
    logic rej;
    logic start_burst;
    logic rd_issue;
    logic issue_last;
    logic [AW+RES_CNT_W-1:0] cnt_ext;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty && i_cmd.op == OP_READ) begin
                    n_state = BK_BURST;
                end
            end
            BK_BURST: begin
                if (r_left == REQ_N_W'(1)) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        rej         = 1'b0;
        start_burst = 1'b0;
        rd_issue    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_pop       = !i_empty;
                mem_we      = !i_empty && (i_cmd.op == OP_PUSH);
                rej         = !i_empty && (i_cmd.op == OP_REJECT);
                start_burst = !i_empty && (i_cmd.op == OP_READ);
            end
            BK_BURST: begin
                rd_issue = 1'b1;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    assign issue_last = (r_left == REQ_N_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_addr] <= i_cmd.sample;
        end
        if (rd_issue) begin
            r_mem_q <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_burst) begin
            r_addr <= i_addr;
            r_left <= i_cmd.n;
            r_cnt  <= i_cnt;
        end else if (rd_issue) begin
            r_addr <= (r_addr == LAST_SLOT) ? '0 : r_addr + 1'b1;
            r_left <= r_left - 1'b1;
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    // The result stage lines up with the registered memory read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= rd_issue || rej;
        end
        r_out_acc  <= rd_issue;
        r_out_last <= rd_issue ? issue_last : 1'b1;
        r_out_cnt  <= rd_issue ? (r_cnt - 1'b1) : i_cnt;
    end

    assign cnt_ext     = {{RES_CNT_W{1'b0}}, r_out_cnt};
    assign o_res_valid = r_out_valid;

    always_comb begin
        o_res.accepted     = r_out_acc;
        o_res.tag_out      = r_out_acc ? r_mem_q.tag    : '0;
        o_res.word_a_out   = r_out_acc ? r_mem_q.word_a : '0;
        o_res.word_b_out   = r_out_acc ? r_mem_q.word_b : '0;
        o_res.word_c_out   = r_out_acc ? r_mem_q.word_c : '0;
        o_res.last         = r_out_last;
        o_res.unread_after = cnt_ext[RES_CNT_W-1:0];
    end

endmodule
